[hw/rtl/fps_pkg.sv]
package fps_pkg;

  // fitness and cumulative widths
  localparam int unsigned CUM_W   = 27;
  localparam int unsigned DOM_W   = 13;
  localparam int unsigned SEL_W   = 16;
  localparam int unsigned DRAW_W  = 16;
  localparam int unsigned FIT_W   = 17;
  localparam int unsigned PROD_W  = DOM_W + SEL_W;
  localparam int unsigned TGT_W   = DRAW_W + CUM_W;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned STAT_W  = 2;

  // fitness of the wild-type individual, 1.0 in Q5.12
  localparam logic [FIT_W-1:0] FIT_ONE = FIT_W'(4096);
  localparam logic [DOM_W-1:0] DOM_MAX = DOM_W'(4096);
  localparam logic [CUM_W-1:0] CUM_MAX = {CUM_W{1'b1}};

  // item functions
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SELECT = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // register map, word index taken from paddr[2]
  localparam int unsigned    ADDR_W       = 3;
  localparam logic           REG_DOMINANCE = 1'b0;
  localparam logic           REG_SEL_COEFF = 1'b1;

  typedef logic [CUM_W-1:0] cum_t;

endpackage

[hw/rtl/fitness_proportionate_selection.sv]
// Roulette-wheel selection over a table of up to MAX_POP diploid individuals.
// A load item (func 0) turns its two allele bits into a Q5.12 fitness of 1,
// 1+h*s or 1+s, adds it to the running total (saturating at 2^27-1) and
// writes that cumulative value into the next table entry; first_of_load
// restarts the table. A select item (func 1) returns the smallest index whose
// cumulative fitness * 65536 is at least draw * total. Every transfer in gives
// exactly one transfer out. A load steps through accept, h*s multiply, add and
// table write, then hand-off. A select steps through accept, draw*total
// multiply, one binary-search step per cycle (bounded by the single read port
// of the cumulative table with its registered read data), then hand-off.
// Errors (select on empty table, load into full table) go straight from
// accept to hand-off. The table needs no clearing after reset; only entries
// below the loaded count are ever used. One item is in flight at a time, and
// a result may wait in the output register while the next item is taken.
module fitness_proportionate_selection
  import fps_pkg::*;
#(
  parameter int unsigned MAX_POP = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_func,
  input  logic                in_first_of_load,
  input  logic                in_first_allele,
  input  logic                in_second_allele,
  input  logic [DRAW_W-1:0]   in_draw,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [IDX_W-1:0]    out_chosen_index,
  output logic [STAT_W-1:0]   out_status,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned AW = (MAX_POP > 1) ? $clog2(MAX_POP) : 1;
  localparam int unsigned CW = $clog2(MAX_POP + 1);
  localparam logic [CW-1:0] POP_FULL = CW'(MAX_POP);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LD_MUL = 3'd1;
  localparam logic [2:0] ST_LD_ADD = 3'd2;
  localparam logic [2:0] ST_SL_MUL = 3'd3;
  localparam logic [2:0] ST_SL_CMP = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  // cumulative fitness table
  cum_t mem [MAX_POP];

  logic [2:0]          state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  cum_t                total_r, total_nxt;
  logic [DOM_W-1:0]    dom_r;
  logic [SEL_W-1:0]    sel_r;
  logic                out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]    out_idx_r, out_idx_nxt;
  logic [STAT_W-1:0]   out_stat_r, out_stat_nxt;

  logic [1:0]          copies_r, copies_nxt;
  logic [DRAW_W-1:0]   draw_r, draw_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [TGT_W-1:0]    target_r, target_nxt;
  logic [AW-1:0]       lo_r, lo_nxt;
  logic [AW-1:0]       hi_r, hi_nxt;
  logic [IDX_W-1:0]    res_idx_r, res_idx_nxt;
  logic [STAT_W-1:0]   res_stat_r, res_stat_nxt;
  cum_t                rd_data_r;

  logic                in_xfer;
  logic                cfg_wr;
  logic [DOM_W-1:0]    dom_eff;
  logic [FIT_W-1:0]    fitness;
  logic [CUM_W:0]      sum_full;
  cum_t                sum_sat;
  logic [AW-1:0]       rd_addr;
  logic                mem_we;
  logic [CW-1:0]       count_eff;
  logic                cmp_ge;
  logic [AW-1:0]       mid_cur;

  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  // register readback
  always_comb begin
    case (paddr[2])
      REG_DOMINANCE: prdata = 32'(dom_r);
      REG_SEL_COEFF: prdata = 32'(sel_r);
      default:       prdata = 32'd0;
    endcase
  end

  // fitness of the captured individual
  assign dom_eff = (dom_r > DOM_MAX) ? DOM_MAX : dom_r;
  always_comb begin
    case (copies_r)
      2'd0:    fitness = FIT_ONE;
      2'd1:    fitness = FIT_ONE + FIT_W'(prod_r >> 12);
      default: fitness = FIT_ONE + FIT_W'(sel_r);
    endcase
  end
  assign sum_full = {1'b0, total_r} + (CUM_W + 1)'(fitness);
  assign sum_sat  = sum_full[CUM_W] ? CUM_MAX : sum_full[CUM_W-1:0];

  // search step compare on the entry read last cycle
  assign cmp_ge  = ({rd_data_r, 16'd0} >= target_r);
  assign mid_cur = lo_r + ((hi_r - lo_r) >> 1);

  assign count_eff = in_first_of_load ? '0 : count_r;

  // next-state logic
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_idx_nxt   = out_idx_r;
    out_stat_nxt  = out_stat_r;
    copies_nxt    = copies_r;
    draw_nxt      = draw_r;
    prod_nxt      = prod_r;
    target_nxt    = target_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    res_idx_nxt   = res_idx_r;
    res_stat_nxt  = res_stat_r;
    mem_we        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          copies_nxt   = {1'b0, in_first_allele} + {1'b0, in_second_allele};
          draw_nxt     = in_draw;
          res_idx_nxt  = '0;
          res_stat_nxt = STAT_OK;
          if (in_func == FUNC_LOAD) begin
            if (in_first_of_load) begin
              count_nxt = '0;
              total_nxt = '0;
            end
            if (count_eff == POP_FULL) begin
              res_stat_nxt = STAT_FULL;
              state_nxt    = ST_DONE;
            end else begin
              state_nxt = ST_LD_MUL;
            end
          end else begin
            if (count_r == '0) begin
              res_stat_nxt = STAT_EMPTY;
              state_nxt    = ST_DONE;
            end else begin
              lo_nxt    = '0;
              hi_nxt    = AW'(count_r - CW'(1));
              state_nxt = ST_SL_MUL;
            end
          end
        end
      end
      ST_LD_MUL: begin
        prod_nxt  = PROD_W'(dom_eff) * PROD_W'(sel_r);
        state_nxt = ST_LD_ADD;
      end
      ST_LD_ADD: begin
        mem_we      = 1'b1;
        total_nxt   = sum_sat;
        count_nxt   = count_r + CW'(1);
        res_idx_nxt = IDX_W'(count_r);
        state_nxt   = ST_DONE;
      end
      ST_SL_MUL: begin
        target_nxt = TGT_W'(draw_r) * TGT_W'(total_r);
        state_nxt  = ST_SL_CMP;
      end
      ST_SL_CMP: begin
        if (lo_r >= hi_r) begin
          res_idx_nxt = IDX_W'(lo_r);
          state_nxt   = ST_DONE;
        end else if (cmp_ge) begin
          hi_nxt = mid_cur;
        end else begin
          lo_nxt = mid_cur + AW'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = res_idx_r;
          out_stat_nxt  = res_stat_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // next search probe, read in the cycle before its compare
  assign rd_addr = lo_nxt + ((hi_nxt - lo_nxt) >> 1);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      dom_r       <= DOM_W'(2048);
      sel_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        case (paddr[2])
          REG_DOMINANCE: dom_r <= pwdata[DOM_W-1:0];
          REG_SEL_COEFF: sel_r <= pwdata[SEL_W-1:0];
          default:       ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    out_idx_r  <= out_idx_nxt;
    out_stat_r <= out_stat_nxt;
    copies_r   <= copies_nxt;
    draw_r     <= draw_nxt;
    prod_r     <= prod_nxt;
    target_r   <= target_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    res_idx_r  <= res_idx_nxt;
    res_stat_r <= res_stat_nxt;
  end

  // table memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[AW-1:0]] <= sum_sat;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_valid        = out_valid_r;
  assign out_chosen_index = out_idx_r;
  assign out_status       = out_stat_r;

`ifndef ASSERT_OFF
  // loaded count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= POP_FULL)
    else $error("loaded count beyond table depth");

  // search window stays ordered and inside the loaded entries
  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SL_CMP) |-> (lo_r <= hi_r) && (CW'(hi_r) < count_r))
    else $error("search window out of range");

  // each table write advances the count by one
  a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LD_ADD) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("load did not advance count");

  // new input is only taken with no result waiting in the hand-off state
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && out_valid_r && out_stall |=> (state_r == ST_DONE))
    else $error("result dropped while output stalled");
`endif

endmodule
